>>> rtl/core/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types, constants and helpers of the stepper position and homing
// controller: coil tables, command and register codes, item structs.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int unsigned POS_W         = 16;
  localparam int unsigned DELAY_W       = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned SEARCH_MARGIN = 200;
  localparam logic [POS_W-1:0] POS_RESET = POS_W'(1000);
  localparam logic [DELAY_W-1:0] CALIB_DELAY_RESET = DELAY_W'(10);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DELAY_W-1:0] delay_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_CAL  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MOVE   = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_MIN     = 3'd0,
    CFG_POS_MAX     = 3'd1,
    CFG_HOME_POS    = 3'd2,
    CFG_CALIB_DELAY = 3'd3,
    CFG_TABLE_SEL   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    pos_t   pos_min;
    pos_t   pos_max;
    pos_t   home_position;
    delay_t calib_step_delay;
    logic   phase_table_select;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [15:0] target;
    delay_t     step_delay;
    logic       end_stop;
  } item_t;

  typedef struct packed {
    logic [3:0] coils;
    pos_t       position;
    logic       busy_res;
    logic       done_res;
    logic       calib_error;
  } res_t;

  localparam logic [3:0] COIL_TABLE [2][8] = '{
    '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9},
    '{4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9}
  };

  function automatic logic [3:0] pattern_of(input logic sel, input pos_t pos);
    return COIL_TABLE[sel][pos[2:0]];
  endfunction

  function automatic delay_t nonzero(input delay_t d);
    return (d == '0) ? DELAY_W'(1) : d;
  endfunction

  function automatic pos_t clamp(input pos_t to, input pos_t lo, input pos_t hi);
    pos_t r;
    r = (to > hi) ? hi : to;
    r = (r < lo) ? lo : r;
    return r;
  endfunction

endpackage

>>> rtl/core/shp_cfg_regs.sv
// ----------------------------------------------------------------------------
// shp_cfg_regs
// Configuration register file: limits, home position, calibration delay
// and coil table select.
// ----------------------------------------------------------------------------
module shp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output shp_pkg::cfg_t                 cfg_o
);
  import shp_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POS_MIN:     cfg_d.pos_min            = POS_W'(cfg_data_i);
        CFG_POS_MAX:     cfg_d.pos_max            = POS_W'(cfg_data_i);
        CFG_HOME_POS:    cfg_d.home_position      = POS_W'(cfg_data_i);
        CFG_CALIB_DELAY: cfg_d.calib_step_delay   = DELAY_W'(cfg_data_i);
        CFG_TABLE_SEL:   cfg_d.phase_table_select = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min            <= '0;
      cfg_q.pos_max            <= POS_RESET;
      cfg_q.home_position      <= '0;
      cfg_q.calib_step_delay   <= CALIB_DELAY_RESET;
      cfg_q.phase_table_select <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/core/shp_in_reg.sv
// ----------------------------------------------------------------------------
// shp_in_reg
// Input register: captures one request and holds it until the step logic
// takes it.
// ----------------------------------------------------------------------------
module shp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  shp_pkg::item_t  item_i,
  input  logic            take_i,
  output logic            valid_o,
  output shp_pkg::item_t  item_o
);
  import shp_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

>>> rtl/core/shp_engine.sv
// ----------------------------------------------------------------------------
// shp_engine
// Motion state and the single-pass step logic: tick counting, move and
// end-stop search, one position step per step instant.
// ----------------------------------------------------------------------------
module shp_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_en_i,
  input  shp_pkg::item_t item_i,
  input  shp_pkg::cfg_t  cfg_i,
  output shp_pkg::res_t  res_o
);
  import shp_pkg::*;

  mode_e      mode_q, mode_d;
  pos_t       cur_q, cur_d;
  pos_t       goal_q, goal_d;
  delay_t     tick_q, tick_d;
  delay_t     delay_q, delay_d;
  pos_t       cnt_q, cnt_d;
  logic [3:0] coil_q, coil_d;
  logic       err_q, err_d;
  logic       done;

  logic       is_idle;
  logic       cmd_move;
  logic       cmd_cal;
  delay_t     tick_inc;
  logic       hit;
  logic [POS_W:0] start_sum;
  pos_t       calib_start;
  pos_t       cnt_src;
  pos_t       cur_src;
  logic       search_go;
  logic       run_search;
  logic       search_fin;
  logic       run_move;
  pos_t       cmd_goal;
  pos_t       home_goal;
  pos_t       mv_cur;
  pos_t       mv_goal;
  logic       mv_at;
  pos_t       mv_next;
  pos_t       srch_next;

  assign is_idle   = (mode_q == MODE_IDLE);
  assign cmd_move  = is_idle && (item_i.action == ACT_MOVE);
  assign cmd_cal   = is_idle && (item_i.action == ACT_CAL);
  assign tick_inc  = tick_q + DELAY_W'(1);
  assign hit       = (tick_inc >= delay_q);

  assign start_sum   = {1'b0, cfg_i.pos_max} + (POS_W+1)'(SEARCH_MARGIN);
  assign calib_start = start_sum[POS_W] ? '1 : start_sum[POS_W-1:0];
  assign cnt_src     = is_idle ? calib_start : cnt_q;
  assign cur_src     = is_idle ? calib_start : cur_q;
  assign search_go   = (cnt_src > cfg_i.pos_min) && !item_i.end_stop;
  assign srch_next   = cur_src - POS_W'(1);

  assign run_search = cmd_cal || ((mode_q == MODE_SEARCH) && hit);
  assign search_fin = run_search && !search_go;
  assign run_move   = cmd_move || ((mode_q == MODE_MOVE) && hit) || search_fin;

  assign cmd_goal  = clamp(POS_W'(item_i.target), cfg_i.pos_min, cfg_i.pos_max);
  assign home_goal = clamp(cfg_i.home_position, cfg_i.pos_min, cfg_i.pos_max);
  assign mv_cur    = search_fin ? cfg_i.pos_min : cur_q;
  assign mv_goal   = (mode_q == MODE_MOVE) ? goal_q : (search_fin ? home_goal : cmd_goal);
  assign mv_at     = (mv_cur == mv_goal);
  assign mv_next   = (mv_cur < mv_goal) ? mv_cur + POS_W'(1) : mv_cur - POS_W'(1);

  always_comb begin
    mode_d  = mode_q;
    cur_d   = cur_q;
    goal_d  = goal_q;
    tick_d  = tick_q;
    delay_d = delay_q;
    cnt_d   = cnt_q;
    coil_d  = coil_q;
    err_d   = err_q;
    done    = 1'b0;

    unique case (mode_q)
      MODE_IDLE: begin
        if (cmd_move) begin
          goal_d  = cmd_goal;
          delay_d = nonzero(item_i.step_delay);
          tick_d  = '0;
        end else if (cmd_cal) begin
          delay_d = nonzero(cfg_i.calib_step_delay);
          tick_d  = '0;
        end
      end
      MODE_MOVE, MODE_SEARCH: begin
        tick_d = hit ? '0 : tick_inc;
      end
      default: ;
    endcase

    if (run_search && search_go) begin
      mode_d = MODE_SEARCH;
      cur_d  = srch_next;
      cnt_d  = cnt_src - POS_W'(1);
      coil_d = pattern_of(cfg_i.phase_table_select, srch_next);
    end

    if (search_fin) begin
      err_d   = !item_i.end_stop;
      goal_d  = home_goal;
      delay_d = nonzero(cfg_i.calib_step_delay);
      cnt_d   = cnt_src;
      tick_d  = '0;
    end

    if (run_move) begin
      if (mv_at) begin
        mode_d = MODE_IDLE;
        cur_d  = mv_cur;
        coil_d = 4'd0;
        done   = 1'b1;
      end else begin
        mode_d = MODE_MOVE;
        cur_d  = mv_next;
        coil_d = pattern_of(cfg_i.phase_table_select, mv_next);
        tick_d = '0;
      end
    end
  end

  assign res_o.coils       = coil_d;
  assign res_o.position    = cur_d;
  assign res_o.busy_res    = (mode_d != MODE_IDLE);
  assign res_o.done_res    = done;
  assign res_o.calib_error = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cur_q   <= POS_RESET;
      goal_q  <= '0;
      tick_q  <= '0;
      delay_q <= DELAY_W'(1);
      cnt_q   <= '0;
      coil_q  <= 4'd0;
      err_q   <= 1'b0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      cur_q   <= cur_d;
      goal_q  <= goal_d;
      tick_q  <= tick_d;
      delay_q <= delay_d;
      cnt_q   <= cnt_d;
      coil_q  <= coil_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> rtl/core/shp_out_reg.sv
// ----------------------------------------------------------------------------
// shp_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module shp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  shp_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output shp_pkg::res_t res_o
);
  import shp_pkg::*;

  logic valid_q;
  logic valid_d;
  res_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign valid_d     = load_i || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/core/stepper_position_homing_ctrl_core.sv
// ----------------------------------------------------------------------------
// stepper_position_homing_ctrl_core
// Half-step stepper controller with absolute position tracking, clamped
// moves and end-stop calibration followed by a homing move.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  in      | in_valid_i / in_stall_o    | action, target, step_delay, end_stop
//  out     | out_valid_o / out_stall_i  | coils, position, busy_res, done_res,
//          |                            | calib_error
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  one request per cycle while the result is not stalled
//  the whole step runs in one pass between the input and result registers
//  reset clears all control state; position comes up at 1000, coils released
//  a stalled result holds; the input register keeps taking requests while
//  the result register has room
// ----------------------------------------------------------------------------
module stepper_position_homing_ctrl_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [15:0]                    target_i,
  input  logic [15:0]                    step_delay_i,
  input  logic                           end_stop_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [3:0]                     coils_o,
  output logic [15:0]                    position_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic                           calib_error_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import shp_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t item_q;
  logic  item_valid;
  logic  out_free;
  logic  advance;
  res_t  step_res;
  res_t  res_q;

  assign in_item.action     = action_i;
  assign in_item.target     = target_i;
  assign in_item.step_delay = step_delay_i;
  assign in_item.end_stop   = end_stop_i;

  assign advance = item_valid && out_free;

  shp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  shp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  shp_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  shp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign coils_o       = res_q.coils;
  assign position_o    = 16'(res_q.position);
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign calib_error_o = res_q.calib_error;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_res_o && busy_res_o))
    else $error("done raised while still busy");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (coils_o == 4'd0))
    else $error("coils energized while idle");

  a_busy_energized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && busy_res_o) |-> (coils_o != 4'd0))
    else $error("coils released while busy");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without downstream backpressure");
`endif

endmodule
